[rtl/sauc_pkg.sv]
// ----------------------------------------------------------------------------
// sauc_pkg: shared types and constants of the size-aware LRU cache unit
// Field widths, result kinds, slot entry layout and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sauc_pkg;

	localparam int ID_W       = 31;
	localparam int SIZE_W     = 32;
	localparam int KIND_W     = 3;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [SIZE_W-1:0] CAP_RESET = 32'd65536;

	// register index, taken from paddr above the byte offset
	localparam logic [CFG_ADDR_W-3:0] REG_TOTAL_CAPACITY = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_EVICTED   = 3'd0,
		KIND_INSERTED  = 3'd1,
		KIND_HIT       = 3'd2,
		KIND_PRESENT   = 3'd3,
		KIND_TOO_BIG   = 3'd4,
		KIND_NOT_FOUND = 3'd5
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN,
		CMD_SHIFT,
		CMD_TAIL_WR,
		CMD_EV_RD,
		CMD_EV_UPD,
		CMD_INS_WR,
		CMD_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		kind_t  kind;
		logic   last;
	} ctl_cmd_t;

	typedef struct packed {
		logic found;
		logic scan_done;
		logic shift_done;
		logic is_lookup;
		logic too_big;
		logic must_evict;
		logic can_emit;
	} dp_status_t;

endpackage

[rtl/sauc_req_if.sv]
// ----------------------------------------------------------------------------
// sauc_req_if: request channel
// Valid/ready channel that carries one insert or lookup request.
// ----------------------------------------------------------------------------
interface sauc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [sauc_pkg::ID_W-1:0]   object_id;
	logic [sauc_pkg::SIZE_W-1:0] object_size;

	modport source (output valid, op, object_id, object_size, input ready);
	modport sink (input valid, op, object_id, object_size, output ready);
endinterface

[rtl/sauc_rsp_if.sv]
// ----------------------------------------------------------------------------
// sauc_rsp_if: result channel
// Valid/ready channel that carries one result of a request.
// ----------------------------------------------------------------------------
interface sauc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sauc_pkg::KIND_W-1:0] kind;
	logic [sauc_pkg::ID_W-1:0]   evicted_id;
	logic [sauc_pkg::SIZE_W-1:0] evicted_size;
	logic [sauc_pkg::SIZE_W-1:0] space_left;
	logic                        last;

	modport source (output valid, kind, evicted_id, evicted_size, space_left, last,
		input ready);
	modport sink (input valid, kind, evicted_id, evicted_size, space_left, last,
		output ready);
endinterface

[rtl/sauc_ctrl.sv]
// ----------------------------------------------------------------------------
// sauc_ctrl: request sequencer
// Walks each request through scan, move-to-tail, evict and insert steps and
// tells the datapath which step to run.
// ----------------------------------------------------------------------------
module sauc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sauc_pkg::dp_status_t status,
	output sauc_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_TAIL,
		S_EV_CHK,
		S_EV_UPD,
		S_INS,
		S_EMIT
	} state_t;

	state_t          state_q;
	sauc_pkg::kind_t kind_q;
	logic            last_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.kind = kind_q;
		cmd.last = last_q;
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? sauc_pkg::CMD_LOAD : sauc_pkg::CMD_NONE;
			S_SCAN:   cmd.op = sauc_pkg::CMD_SCAN;
			S_SHIFT:  cmd.op = sauc_pkg::CMD_SHIFT;
			S_TAIL:   cmd.op = sauc_pkg::CMD_TAIL_WR;
			S_EV_CHK: cmd.op = sauc_pkg::CMD_EV_RD;
			S_EV_UPD: cmd.op = sauc_pkg::CMD_EV_UPD;
			S_INS:    cmd.op = sauc_pkg::CMD_INS_WR;
			S_EMIT:   cmd.op = sauc_pkg::CMD_EMIT;
			default:  cmd.op = sauc_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= sauc_pkg::KIND_EVICTED;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (status.found) begin
						if (status.is_lookup) begin
							state_q <= S_SHIFT;
						end else begin
							kind_q  <= sauc_pkg::KIND_PRESENT;
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end
					end else if (status.scan_done) begin
						if (status.is_lookup) begin
							kind_q  <= sauc_pkg::KIND_NOT_FOUND;
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end else if (status.too_big) begin
							kind_q  <= sauc_pkg::KIND_TOO_BIG;
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_EV_CHK;
						end
					end
				end
				S_SHIFT: begin
					if (status.shift_done) state_q <= S_TAIL;
				end
				S_TAIL: begin
					kind_q  <= sauc_pkg::KIND_HIT;
					last_q  <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EV_CHK: begin
					state_q <= status.must_evict ? S_EV_UPD : S_INS;
				end
				S_EV_UPD: begin
					kind_q  <= sauc_pkg::KIND_EVICTED;
					last_q  <= 1'b0;
					state_q <= S_EMIT;
				end
				S_INS: begin
					kind_q  <= sauc_pkg::KIND_INSERTED;
					last_q  <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// an eviction is never last: go check whether another is needed
					if (status.can_emit) state_q <= last_q ? S_IDLE : S_EV_CHK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/sauc_datapath.sv]
// ----------------------------------------------------------------------------
// sauc_datapath: slot memory, occupancy and result register
// Slots live in a circular buffer, logical slot 0 (oldest) at head_q. One
// memory read and one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sauc_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sauc_pkg::ctl_cmd_t          cmd,
	output sauc_pkg::dp_status_t        status,
	input  logic                        in_op,
	input  logic [sauc_pkg::ID_W-1:0]   in_object_id,
	input  logic [sauc_pkg::SIZE_W-1:0] in_object_size,
	input  logic [sauc_pkg::SIZE_W-1:0] total_capacity,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [sauc_pkg::KIND_W-1:0] out_kind,
	output logic [sauc_pkg::ID_W-1:0]   out_evicted_id,
	output logic [sauc_pkg::SIZE_W-1:0] out_evicted_size,
	output logic [sauc_pkg::SIZE_W-1:0] out_space_left,
	output logic                        out_last
);

	localparam int AW = $clog2(ENTRIES);
	localparam int IW = $clog2(ENTRIES + 1);
	localparam int PW = IW + 1;

	sauc_pkg::entry_t slot_mem_q [ENTRIES];

	logic [AW-1:0]               head_q;
	logic [IW-1:0]               count_q;
	logic [sauc_pkg::SIZE_W-1:0] used_q;
	logic                        op_q;
	logic [sauc_pkg::ID_W-1:0]   id_q;
	logic [sauc_pkg::SIZE_W-1:0] size_q;
	logic [sauc_pkg::SIZE_W-1:0] hit_size_q;
	logic [sauc_pkg::ID_W-1:0]   ev_id_q;
	logic [sauc_pkg::SIZE_W-1:0] ev_size_q;
	logic [IW-1:0]               idx_q;
	logic                        rd_valid_s1;
	logic [IW-1:0]               rd_idx_s1;
	sauc_pkg::entry_t            rd_data_s1;

	logic                        out_valid_q;
	logic [sauc_pkg::KIND_W-1:0] out_kind_q;
	logic [sauc_pkg::ID_W-1:0]   out_eid_q;
	logic [sauc_pkg::SIZE_W-1:0] out_esize_q;
	logic [sauc_pkg::SIZE_W-1:0] out_space_q;
	logic                        out_last_q;

	logic [PW-1:0]               idx_next1;
	logic                        more_shift;
	logic                        hit_now;
	logic                        emit_now;
	logic [sauc_pkg::SIZE_W-1:0] free_space;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	sauc_pkg::entry_t            wr_data;

	// logical slot to memory row; head + index stays below twice the depth
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
		input logic [PW-1:0] lidx);
		logic [PW-1:0] sum;
		sum = PW'(head) + lidx;
		if (sum >= PW'(ENTRIES)) sum = sum - PW'(ENTRIES);
		return sum[AW-1:0];
	endfunction

	assign idx_next1  = {1'b0, idx_q} + PW'(1);
	assign more_shift = idx_next1 < {1'b0, count_q};
	assign hit_now    = rd_valid_s1 && (rd_data_s1.id == id_q);
	assign emit_now   = (cmd.op == sauc_pkg::CMD_EMIT) && status.can_emit;
	assign free_space = (used_q >= total_capacity) ? '0 : total_capacity - used_q;

	always_comb begin
		status.found      = (cmd.op == sauc_pkg::CMD_SCAN) && hit_now;
		status.scan_done  = !rd_valid_s1 && (idx_q == count_q);
		status.shift_done = !rd_valid_s1 && !more_shift;
		status.is_lookup  = op_q;
		status.too_big    = size_q > total_capacity;
		status.must_evict = (count_q != '0) &&
			((count_q == IW'(ENTRIES)) || (free_space < size_q));
		status.can_emit   = !out_valid_q || out_ready;
	end

	always_comb begin
		case (cmd.op)
			sauc_pkg::CMD_EV_RD: rd_addr = head_q;
			sauc_pkg::CMD_SHIFT: rd_addr = phys(head_q, idx_next1);
			default:             rd_addr = phys(head_q, {1'b0, idx_q});
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, {1'b0, count_q});
		wr_data = '{id: id_q, size: size_q};
		case (cmd.op)
			sauc_pkg::CMD_SHIFT: begin
				// close the gap: slot j takes what slot j+1 held
				wr_en   = rd_valid_s1;
				wr_addr = phys(head_q, {1'b0, rd_idx_s1});
				wr_data = rd_data_s1;
			end
			sauc_pkg::CMD_TAIL_WR: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, {1'b0, count_q} - PW'(1));
				wr_data = '{id: id_q, size: hit_size_q};
			end
			sauc_pkg::CMD_INS_WR: begin
				wr_en = 1'b1;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_mem_q[wr_addr] <= wr_data;
		rd_data_s1 <= slot_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				sauc_pkg::CMD_LOAD: begin
					idx_q       <= '0;
					rd_valid_s1 <= 1'b0;
				end
				sauc_pkg::CMD_SCAN: begin
					if (hit_now) begin
						// hold the match position for the move-to-tail pass
						idx_q       <= rd_idx_s1;
						rd_valid_s1 <= 1'b0;
					end else if (idx_q != count_q) begin
						idx_q       <= idx_q + IW'(1);
						rd_valid_s1 <= 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
					end
				end
				sauc_pkg::CMD_SHIFT: begin
					if (more_shift) begin
						idx_q       <= idx_next1[IW-1:0];
						rd_valid_s1 <= 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
					end
				end
				sauc_pkg::CMD_EV_UPD: begin
					head_q  <= (head_q == AW'(ENTRIES - 1)) ? '0 : head_q + AW'(1);
					count_q <= count_q - IW'(1);
					used_q  <= (rd_data_s1.size >= used_q) ? '0 : used_q - rd_data_s1.size;
				end
				sauc_pkg::CMD_INS_WR: begin
					count_q <= count_q + IW'(1);
					used_q  <= used_q + size_q;
				end
				default: begin
					rd_valid_s1 <= rd_valid_s1;
				end
			endcase

			if (emit_now) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (cmd.op == sauc_pkg::CMD_LOAD) begin
			op_q   <= in_op;
			id_q   <= in_object_id;
			size_q <= in_object_size;
		end
		if ((cmd.op == sauc_pkg::CMD_SCAN) && hit_now) hit_size_q <= rd_data_s1.size;
		if (cmd.op == sauc_pkg::CMD_EV_UPD) begin
			ev_id_q   <= rd_data_s1.id;
			ev_size_q <= rd_data_s1.size;
		end
		if (emit_now) begin
			out_kind_q  <= cmd.kind;
			out_last_q  <= cmd.last;
			out_space_q <= free_space;
			if (cmd.kind == sauc_pkg::KIND_EVICTED) begin
				out_eid_q   <= ev_id_q;
				out_esize_q <= ev_size_q;
			end else begin
				out_eid_q   <= '0;
				out_esize_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_evicted_id   = out_eid_q;
	assign out_evicted_size = out_esize_q;
	assign out_space_left   = out_space_q;
	assign out_last         = out_last_q;

endmodule

[rtl/size_aware_lru_cache_unit.sv]
// ----------------------------------------------------------------------------
// size_aware_lru_cache_unit: byte-capacity LRU cache of variable-size objects
// Holds up to ENTRIES objects in recency order under a programmable capacity.
// Inserts evict the oldest entries until the object fits; lookups move a hit
// to most recent. One or more results per request, the final one marked last.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | transaction
//  ---------+-----+------------------+-------------------------------------
//  req      | in  | valid/ready      | op, object_id, object_size
//  rsp      | out | valid/ready      | kind, evicted_id, evicted_size,
//           |     |                  | space_left, last
//  apb      | in  | psel/penable     | total_capacity at byte address 0
//
// One request at a time; the slot memory has one read port. A request is accepted,
// then the held slots are scanned in order, stopping early on a match.
// A lookup hit then moves the younger slots down and writes the hit at the tail;
// an insert checks for and performs evictions one at a time, then writes the object.
// Reset clears occupancy and restores the capacity; slot contents are not cleared.
// rsp stalls hold the result register and the sequencer; req waits for the last result.
//
module size_aware_lru_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sauc_req_if.sink                             req,
	sauc_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sauc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [sauc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [sauc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	sauc_pkg::ctl_cmd_t          cmd;
	sauc_pkg::dp_status_t        status;
	logic [sauc_pkg::SIZE_W-1:0] capacity_q;
	logic                        cfg_write;
	logic [sauc_pkg::CFG_ADDR_W-3:0] reg_index;

	// APB: zero wait states; writes land on the access phase
	assign pready    = 1'b1;
	assign reg_index = paddr[sauc_pkg::CFG_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (reg_index == sauc_pkg::REG_TOTAL_CAPACITY) ? capacity_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sauc_pkg::CAP_RESET;
		end else if (cfg_write && (reg_index == sauc_pkg::REG_TOTAL_CAPACITY)) begin
			// drop writes to unmapped addresses
			capacity_q <= pwdata;
		end
	end

	sauc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	sauc_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_op            (req.op),
		.in_object_id     (req.object_id),
		.in_object_size   (req.object_size),
		.total_capacity   (capacity_q),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_kind         (rsp.kind),
		.out_evicted_id   (rsp.evicted_id),
		.out_evicted_size (rsp.evicted_size),
		.out_space_left   (rsp.space_left),
		.out_last         (rsp.last)
	);

	// an eviction is always followed by the insert that caused it
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.last && (rsp.kind == sauc_pkg::KIND_EVICTED)))
		else $error("eviction marked as final result");

	// evicted fields carry data only on evictions
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind != sauc_pkg::KIND_EVICTED)) |->
		((rsp.evicted_id == '0) && (rsp.evicted_size == '0)))
		else $error("evicted fields set on a non-eviction result");

	// an accepted request drops ready in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// a request is only taken when the sequencer has nothing pending
	assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> ((cmd.op == sauc_pkg::CMD_LOAD) || (cmd.op == sauc_pkg::CMD_NONE)))
		else $error("request port open during sequencing");

endmodule
